// ===== rtl/core/onewire_temp_poll_alarm_macros.svh =====
// Assertion helpers shared by the one-wire poller RTL.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef ONEWIRE_TEMP_POLL_ALARM_MACROS_SVH
`define ONEWIRE_TEMP_POLL_ALARM_MACROS_SVH

// Check an expression on every clock edge outside reset.
`define OWTP_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("owtp assertion failed");

// Check that a condition is followed by an expression on the next clock edge.
`define OWTP_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("owtp assertion failed");

`endif

// ===== rtl/core/owtp_pkg.sv =====
package owtp_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ALARM_LIMIT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE       = 3'd5;

    localparam logic signed [15:0] ALARM_LIMIT_RST = 16'sd330;
    localparam logic [15:0] RESET_LOW_RST = 16'd480;
    localparam logic [15:0] RECOVERY_RST  = 16'd5000;
    localparam logic [15:0] SLOT_RST      = 16'd60;
    localparam logic [7:0]  SHORT_LOW_RST = 8'd2;
    localparam logic [7:0]  SAMPLE_RST    = 8'd10;

    localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
    localparam logic [7:0] CMD_CONVERT      = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    typedef struct packed {
        logic signed [15:0] alarm_limit;
        logic [15:0]        reset_low_ticks;
        logic [15:0]        recovery_ticks;
        logic [15:0]        slot_ticks;
        logic [7:0]         short_low_ticks;
        logic [7:0]         sample_ticks;
    } cfg_t;

    typedef struct packed {
        logic               drive_low;
        logic signed [15:0] temp_tenths;
        logic               temp_valid;
        logic               over_limit;
    } result_t;

    // Signed 1/16 degree count to rounded tenths, truncated toward zero.
    function automatic logic signed [15:0] tenths_from_raw(input logic signed [15:0] raw);
        logic signed [19:0] wide;
        logic signed [19:0] sum;
        logic signed [19:0] quo;
        begin
            wide = {{4{raw[15]}}, raw};
            sum  = (wide <<< 3) + (wide <<< 1) + 20'sd8;
            if (sum < 0)
            begin
                quo = (sum + 20'sd15) >>> 4;
            end
            else
            begin
                quo = sum >>> 4;
            end
            return quo[15:0];
        end
    endfunction

endpackage

// ===== rtl/core/owtp_in_if.sv =====
interface owtp_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink (input valid, input line_level, output ready);
endinterface

// ===== rtl/core/owtp_out_if.sv =====
interface owtp_out_if;
    logic               valid;
    logic               ready;
    logic               drive_low;
    logic signed [15:0] temp_tenths;
    logic               temp_valid;
    logic               over_limit;

    modport source (output valid, output drive_low, output temp_tenths,
                    output temp_valid, output over_limit, input ready);
    modport sink (input valid, input drive_low, input temp_tenths,
                  input temp_valid, input over_limit, output ready);
endinterface

// ===== rtl/core/owtp_cfg_if.sv =====
interface owtp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [owtp_pkg::CFG_IDX_W-1:0]   index;
    logic [owtp_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/owtp_cfg.sv =====
module owtp_cfg (
    input  logic              clk,
    input  logic              rst_n,
    owtp_cfg_if.sink          cfg_ch,
    output owtp_pkg::cfg_t    cfg
);

    owtp_pkg::cfg_t cfg_reg;

    assign cfg_ch.ready = 1'b1;
    assign cfg = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_limit     <= owtp_pkg::ALARM_LIMIT_RST;
            cfg_reg.reset_low_ticks <= owtp_pkg::RESET_LOW_RST;
            cfg_reg.recovery_ticks  <= owtp_pkg::RECOVERY_RST;
            cfg_reg.slot_ticks      <= owtp_pkg::SLOT_RST;
            cfg_reg.short_low_ticks <= owtp_pkg::SHORT_LOW_RST;
            cfg_reg.sample_ticks    <= owtp_pkg::SAMPLE_RST;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_ch.index)
                owtp_pkg::REG_ALARM_LIMIT: cfg_reg.alarm_limit     <= cfg_ch.data;
                owtp_pkg::REG_RESET_LOW:   cfg_reg.reset_low_ticks <= cfg_ch.data;
                owtp_pkg::REG_RECOVERY:    cfg_reg.recovery_ticks  <= cfg_ch.data;
                owtp_pkg::REG_SLOT:        cfg_reg.slot_ticks      <= cfg_ch.data;
                owtp_pkg::REG_SHORT_LOW:   cfg_reg.short_low_ticks <= cfg_ch.data[7:0];
                owtp_pkg::REG_SAMPLE:      cfg_reg.sample_ticks    <= cfg_ch.data[7:0];
                default: ;  // drop writes past the register list
            endcase
        end
    end

endmodule

// ===== rtl/core/owtp_seq.sv =====
`include "onewire_temp_poll_alarm_macros.svh"

module owtp_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic              line_level,
    input  owtp_pkg::cfg_t    cfg,
    output owtp_pkg::result_t res
);

    localparam logic [3:0] PH_RST1_LOW = 4'd0;
    localparam logic [3:0] PH_RST1_REC = 4'd1;
    localparam logic [3:0] PH_WR_SKIP1 = 4'd2;
    localparam logic [3:0] PH_WR_CONV  = 4'd3;
    localparam logic [3:0] PH_RST2_LOW = 4'd4;
    localparam logic [3:0] PH_RST2_REC = 4'd5;
    localparam logic [3:0] PH_WR_SKIP2 = 4'd6;
    localparam logic [3:0] PH_WR_READ  = 4'd7;
    localparam logic [3:0] PH_READ     = 4'd8;

    logic [3:0]         phase_reg, phase_next;
    logic [15:0]        tick_reg, tick_next;
    logic [2:0]         bit_reg, bit_next;
    logic               byte_reg, byte_next;
    logic [7:0]         shift_reg, shift_next;
    logic [7:0]         low_reg, low_next;
    logic signed [15:0] temp_reg, temp_next;
    logic               alarm_reg, alarm_next;

    logic [3:0]  ph;
    logic [16:0] nt;
    logic [7:0]  cmd;
    logic        cmd_bit;
    logic        slot_end;
    logic [15:0] last_tick;
    logic [15:0] sample_at;
    logic        drive;
    logic        done;
    logic        slot_phase;

    always_comb
    begin
        ph = (phase_reg > PH_READ) ? PH_RST1_LOW : phase_reg;
        nt = {1'b0, tick_reg} + 17'd1;
        if (ph == PH_WR_CONV)
        begin
            cmd = owtp_pkg::CMD_CONVERT;
        end
        else if (ph == PH_WR_READ)
        begin
            cmd = owtp_pkg::CMD_READ_SCRATCH;
        end
        else
        begin
            cmd = owtp_pkg::CMD_SKIP_ROM;
        end
        cmd_bit   = cmd[bit_reg];
        slot_end  = nt >= {1'b0, cfg.slot_ticks};
        last_tick = (cfg.slot_ticks == 16'd0) ? 16'd0 : cfg.slot_ticks - 16'd1;
        sample_at = ({8'd0, cfg.sample_ticks} > last_tick) ? last_tick
                                                           : {8'd0, cfg.sample_ticks};

        phase_next = ph;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        shift_next = shift_reg;
        low_next   = low_reg;
        temp_next  = temp_reg;
        alarm_next = alarm_reg;
        drive      = 1'b0;
        done       = 1'b0;
        tick_next  = nt[15:0];

        unique case (ph) inside
            PH_RST1_LOW, PH_RST2_LOW:
            begin
                drive = tick_reg < cfg.reset_low_ticks;
                if (nt >= {1'b0, cfg.reset_low_ticks})
                begin
                    phase_next = ph + 4'd1;
                    tick_next  = 16'd0;
                end
            end
            PH_RST1_REC, PH_RST2_REC:
            begin
                if (nt >= {1'b0, cfg.recovery_ticks})
                begin
                    phase_next = ph + 4'd1;
                    tick_next  = 16'd0;
                end
            end
            PH_WR_SKIP1, PH_WR_CONV, PH_WR_SKIP2, PH_WR_READ:
            begin
                drive = cmd_bit ? (tick_reg < {8'd0, cfg.short_low_ticks})
                                : !slot_end;
                if (slot_end)
                begin
                    tick_next = 16'd0;
                    bit_next  = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        phase_next = ph + 4'd1;
                    end
                end
            end
            PH_READ:
            begin
                drive = tick_reg < {8'd0, cfg.short_low_ticks};
                if (tick_reg == sample_at)
                begin
                    shift_next = {line_level, shift_reg[7:1]};
                end
                if (slot_end)
                begin
                    tick_next = 16'd0;
                    bit_next  = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        if (!byte_reg)
                        begin
                            low_next  = shift_next;
                            byte_next = 1'b1;
                        end
                        else
                        begin
                            temp_next  = owtp_pkg::tenths_from_raw({shift_next, low_reg});
                            alarm_next = temp_next > cfg.alarm_limit;
                            byte_next  = 1'b0;
                            done       = 1'b1;
                            phase_next = PH_RST1_LOW;
                        end
                    end
                end
            end
            default: ;
        endcase

        res.drive_low   = drive;
        res.temp_tenths = temp_next;
        res.temp_valid  = done;
        res.over_limit  = alarm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_RST1_LOW;
            tick_reg  <= 16'd0;
            bit_reg   <= 3'd0;
            byte_reg  <= 1'b0;
            shift_reg <= 8'd0;
            low_reg   <= 8'd0;
            temp_reg  <= 16'sd0;
            alarm_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            shift_reg <= shift_next;
            low_reg   <= low_next;
            temp_reg  <= temp_next;
            alarm_reg <= alarm_next;
        end
    end

    // Command byte slots and the read slots.
    assign slot_phase = phase_reg >= PH_WR_SKIP1 && phase_reg <= PH_READ
                        && phase_reg != PH_RST2_LOW && phase_reg != PH_RST2_REC;

    // The high byte is only ever pending inside the read phase.
    `OWTP_ASSERT(a_byte_in_read, !byte_reg || phase_reg == PH_READ)
    // Bit position only moves in command and read phases.
    `OWTP_ASSERT(a_bit_in_slots, bit_reg == 3'd0 || slot_phase)

endmodule

// ===== rtl/core/onewire_temp_poll_alarm.sv =====
// One-wire temperature poller. Every beat on line_ch is one bus timing tick
// carrying the sampled data line level; every tick yields exactly one beat on
// result_ch with the pull-low drive for that tick, the latest temperature in
// tenths of a degree, a one-tick temp_valid strobe when a new reading lands,
// and the alarm flag (reading above alarm_limit, refreshed only when a new
// reading lands). The block loops forever: reset pulse, recovery gap,
// skip-ROM, convert, reset pulse, recovery gap, skip-ROM, read-scratchpad,
// then two bytes read LSB first; the raw signed 1/16 degree count becomes
// trunc_toward_zero((raw*10+8)/16). Presence is not checked. Throughput is one
// tick per clock while result_ch is ready; a tick enters the input
// register on accept and its result reaches the result register on the
// next advance. The sequencer state updates in one pass between
// those two registers. Write cfg_ch (always ready) only while no tick is in
// flight; register indexes: 0 alarm_limit, 1 reset_low_ticks, 2 recovery_ticks,
// 3 slot_ticks, 4 short_low_ticks, 5 sample_ticks. Other indexes are ignored.
`include "onewire_temp_poll_alarm_macros.svh"

module onewire_temp_poll_alarm (
    input  logic        clk,
    input  logic        rst_n,
    owtp_in_if.sink     line_ch,
    owtp_out_if.source  result_ch,
    owtp_cfg_if.sink    cfg_ch
);

    owtp_pkg::cfg_t    cfg;
    owtp_pkg::result_t res;

    // Input stage: hold one accepted tick.
    logic s1_valid_reg;
    logic s1_level_reg;
    // Result stage.
    logic               out_valid_reg;
    logic               out_drive_reg;
    logic signed [15:0] out_temp_reg;
    logic               out_tvalid_reg;
    logic               out_alarm_reg;

    logic advance;

    // Advance the held tick whenever the result register is free or draining.
    assign advance       = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign line_ch.ready = !s1_valid_reg || advance;

    owtp_cfg u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    owtp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .line_level (s1_level_reg),
        .cfg        (cfg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (line_ch.ready)
            begin
                s1_valid_reg <= line_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: load on accept / advance, no reset needed.
    always_ff @(posedge clk)
    begin
        if (line_ch.valid && line_ch.ready)
        begin
            s1_level_reg <= line_ch.line_level;
        end
        if (advance)
        begin
            out_drive_reg  <= res.drive_low;
            out_temp_reg   <= res.temp_tenths;
            out_tvalid_reg <= res.temp_valid;
            out_alarm_reg  <= res.over_limit;
        end
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.drive_low   = out_drive_reg;
    assign result_ch.temp_tenths = out_temp_reg;
    assign result_ch.temp_valid  = out_tvalid_reg;
    assign result_ch.over_limit  = out_alarm_reg;

    // A held tick with a free result register must move on the next edge.
    `OWTP_ASSERT_NEXT(a_fill_result, s1_valid_reg && !out_valid_reg, out_valid_reg)
    // A stalled tick stays put with its level.
    `OWTP_ASSERT_NEXT(a_hold_tick, s1_valid_reg && !advance, s1_valid_reg && $stable(s1_level_reg))
    // Converted readings stay inside the sensor span.
    `OWTP_ASSERT(a_temp_span, !out_valid_reg || (out_temp_reg >= -16'sd20479 && out_temp_reg <= 16'sd20479))

endmodule

// ===== dv/onewire_temp_poll_alarm_test.sv =====
`timescale 1ns / 100ps

module onewire_temp_poll_alarm_test;
    import owtp_pkg::*;

    // Run guard: far above the slowest legal run, including the long hold-off
    localparam int RUN_LIMIT   = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_TICKS = 200;
    localparam int RANDOM_READINGS = 1;

    // Config indexes the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // Sequencer phases, in bus order
    typedef enum logic [3:0] {
        PH_RESET1,
        PH_RECOVER1,
        PH_SKIP1,
        PH_CONVERT,
        PH_RESET2,
        PH_RECOVER2,
        PH_SKIP2,
        PH_READ_CMD,
        PH_READ_BYTES
    } bus_phase_t;

    // One pending tick: either a free line level, or a word whose bits are
    // played back on the line while the block reads the scratchpad.
    typedef struct packed {
        logic        level;
        logic        follow;
        logic [15:0] word;
    } bus_tick_t;

    logic clk = 1'b0;
    logic rst_n;

    owtp_in_if  line_ch();
    owtp_out_if result_ch();
    owtp_cfg_if cfg_ch();

    onewire_temp_poll_alarm dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .line_ch   (line_ch),
        .result_ch (result_ch),
        .cfg_ch    (cfg_ch)
    );

    // Free-running clock, 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow of the sequencer, advanced once per accepted line beat
    cfg_t        bus_cfg;
    bus_phase_t  bus_phase;
    logic [15:0] tick_count;
    logic [2:0]  bit_idx;
    logic        second_byte;
    logic [7:0]  shift_byte;
    logic [7:0]  low_byte;
    logic [15:0] last_temp;
    logic        alarm;

    bus_tick_t pending_ticks[$];
    result_t   expected_results[$];
    result_t   want;

    int  items_queued = 0;
    int  items_taken = 0;
    int  readings_done = 0;
    int  fail_count = 0;
    int  cycle_count = 0;
    int  holds_asked = 0;
    int  holds_done = 0;
    int  hold_left = 0;
    bit  idle_on = 1'b1;
    logic line_taken = 1'b0;
    logic cfg_taken = 1'b0;
    logic [15:0] cur_word = 16'h0000;

    // Advance the shadow sequencer by one tick and build the result it yields.
    task automatic predict_tick(input logic level, output result_t r);
        logic [16:0] nxt;
        logic [15:0] slot_last;
        logic [15:0] sample_at;
        logic [7:0]  cmd;
        logic        wrap;
        int          raw;
        int          tenths;
        int          limit_val;
        r = '0;
        nxt = {1'b0, tick_count} + 17'd1;
        wrap = 1'b0;
        case (bus_phase)
            PH_RESET1, PH_RESET2:
            begin
                r.drive_low = tick_count < bus_cfg.reset_low_ticks;
                wrap = nxt >= {1'b0, bus_cfg.reset_low_ticks};
                if (wrap)
                begin
                    bus_phase = bus_phase_t'(bus_phase + 4'd1);
                end
            end
            PH_RECOVER1, PH_RECOVER2:
            begin
                wrap = nxt >= {1'b0, bus_cfg.recovery_ticks};
                if (wrap)
                begin
                    bus_phase = bus_phase_t'(bus_phase + 4'd1);
                end
            end
            PH_READ_BYTES:
            begin
                // Sample point clamps to the last tick of the slot
                slot_last = (bus_cfg.slot_ticks != 16'd0) ? bus_cfg.slot_ticks - 16'd1 : 16'd0;
                sample_at = {8'd0, bus_cfg.sample_ticks};
                if (sample_at > slot_last)
                begin
                    sample_at = slot_last;
                end
                r.drive_low = tick_count < {8'd0, bus_cfg.short_low_ticks};
                if (tick_count == sample_at)
                begin
                    shift_byte = {level, shift_byte[7:1]};
                end
                wrap = nxt >= {1'b0, bus_cfg.slot_ticks};
                if (wrap && bit_idx == 3'd7)
                begin
                    bit_idx = 3'd0;
                    if (!second_byte)
                    begin
                        low_byte = shift_byte;
                        second_byte = 1'b1;
                    end
                    else
                    begin
                        // 1/16 degree count to tenths, rounded, toward zero
                        raw = $signed({shift_byte, low_byte});
                        tenths = (raw * 10 + 8) / 16;
                        limit_val = $signed(bus_cfg.alarm_limit);
                        last_temp = tenths[15:0];
                        alarm = tenths > limit_val;
                        second_byte = 1'b0;
                        r.temp_valid = 1'b1;
                        bus_phase = PH_RESET1;
                        readings_done++;
                    end
                end
                else if (wrap)
                begin
                    bit_idx = bit_idx + 3'd1;
                end
            end
            default:
            begin
                // Command byte slots, LSB first
                cmd = (bus_phase == PH_CONVERT) ? CMD_CONVERT :
                      (bus_phase == PH_READ_CMD) ? CMD_READ_SCRATCH : CMD_SKIP_ROM;
                r.drive_low = cmd[bit_idx] ? (tick_count < {8'd0, bus_cfg.short_low_ticks})
                                           : (nxt < {1'b0, bus_cfg.slot_ticks});
                wrap = nxt >= {1'b0, bus_cfg.slot_ticks};
                if (wrap && bit_idx == 3'd7)
                begin
                    bit_idx = 3'd0;
                    bus_phase = bus_phase_t'(bus_phase + 4'd1);
                end
                else if (wrap)
                begin
                    bit_idx = bit_idx + 3'd1;
                end
            end
        endcase
        tick_count = wrap ? 16'd0 : nxt[15:0];
        r.temp_tenths = last_temp;
        r.over_limit = alarm;
    endtask

    // Ticks in one full polling round under the current timing
    function automatic int round_ticks();
        int rl;
        int rec;
        int sl;
        rl  = (bus_cfg.reset_low_ticks == 16'd0) ? 1 : int'(bus_cfg.reset_low_ticks);
        rec = (bus_cfg.recovery_ticks == 16'd0) ? 1 : int'(bus_cfg.recovery_ticks);
        sl  = (bus_cfg.slot_ticks == 16'd0) ? 1 : int'(bus_cfg.slot_ticks);
        return 2 * (rl + rec) + 48 * sl;
    endfunction

    // Push ticks for the driver. With hold_word set the scratchpad word stays
    // fixed; otherwise swap it now and then, leaning on extremes and values
    // around the alarm threshold. noise_pct of the ticks ignore the word.
    task automatic queue_ticks(input int count, input int noise_pct, input bit hold_word);
        bus_tick_t t;
        int        near;
        for (int i = 0; i < count; i++)
        begin
            if (!hold_word && $urandom_range(63) == 0)
            begin
                near = ($signed(bus_cfg.alarm_limit) * 16) / 10
                       + int'($urandom_range(6)) - 3;
                case ($urandom_range(7))
                    0: cur_word = 16'h7FFF;
                    1: cur_word = 16'h8000;
                    2: cur_word = 16'h0000;
                    3: cur_word = 16'hFFFF;
                    4, 5: cur_word = near[15:0];
                    default: cur_word = 16'($urandom);
                endcase
            end
            t.level  = 1'($urandom_range(1));
            t.follow = $urandom_range(99) >= noise_pct;
            t.word   = cur_word;
            pending_ticks.push_back(t);
            items_queued++;
        end
    endtask

    // Block until every queued tick was taken and every result came back
    task automatic wait_idle();
        while (items_taken != items_queued || expected_results.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
        begin
            @(negedge clk);
        end
        while (!cfg_taken);
        cfg_ch.valid <= 1'b0;
    endtask

    // Write all six registers; 8-bit fields get junk in the upper byte
    task automatic apply_timing(input logic [15:0] limit, input logic [15:0] rl,
                                input logic [15:0] rec, input logic [15:0] slot,
                                input logic [7:0] short_low, input logic [7:0] sample);
        write_reg(REG_ALARM_LIMIT, limit);
        write_reg(REG_RESET_LOW, rl);
        write_reg(REG_RECOVERY, rec);
        write_reg(REG_SLOT, slot);
        write_reg(REG_SHORT_LOW, {8'($urandom), short_low});
        write_reg(REG_SAMPLE, {8'($urandom), sample});
    endtask

    // Play one fixed scratchpad word through one full round; the sequencer
    // sits at the start of a reset pulse, so the round ends on a reading.
    task automatic run_word(input logic [15:0] word);
        cur_word = word;
        queue_ticks(round_ticks(), 0, 1'b1);
        wait_idle();
    endtask

    // Line driver: present the next tick once the previous beat is gone,
    // and pick the line level from the shadow state so that the scratchpad
    // bits land on the sample tick.
    always @(negedge clk)
    begin
        if (rst_n && (!line_ch.valid || line_taken))
        begin
            if (pending_ticks.size() != 0 && !(idle_on && $urandom_range(99) < 10))
            begin
                line_ch.valid <= 1'b1;
                if (pending_ticks[0].follow && bus_phase == PH_READ_BYTES)
                begin
                    line_ch.line_level <= pending_ticks[0].word[{second_byte, bit_idx}];
                end
                else
                begin
                    line_ch.line_level <= pending_ticks[0].level;
                end
                void'(pending_ticks.pop_front());
            end
            else
            begin
                line_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: random back-pressure, plus long hold-offs on request
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                result_ch.ready <= 1'b0;
            end
            else if (holds_done != holds_asked)
            begin
                holds_done <= holds_done + 1;
                hold_left <= HOLD_CYCLES;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= !(idle_on && $urandom_range(99) < 10);
            end
        end
    end

    // Monitor: track handshakes, advance the shadow, check each result beat
    always @(posedge clk)
    begin
        line_taken <= line_ch.valid && line_ch.ready;
        cfg_taken  <= cfg_ch.valid && cfg_ch.ready;
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                REG_ALARM_LIMIT: bus_cfg.alarm_limit = cfg_ch.data;
                REG_RESET_LOW:   bus_cfg.reset_low_ticks = cfg_ch.data;
                REG_RECOVERY:    bus_cfg.recovery_ticks = cfg_ch.data;
                REG_SLOT:        bus_cfg.slot_ticks = cfg_ch.data;
                REG_SHORT_LOW:   bus_cfg.short_low_ticks = cfg_ch.data[7:0];
                REG_SAMPLE:      bus_cfg.sample_ticks = cfg_ch.data[7:0];
                default: ;
            endcase
        end
        if (rst_n && line_ch.valid && line_ch.ready)
        begin
            predict_tick(line_ch.line_level, want);
            expected_results.push_back(want);
            items_taken++;
        end
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result beat arrived with nothing expected");
                fail_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_ch.drive_low !== want.drive_low)
                begin
                    $error("drive_low: expected %0b, got %0b", want.drive_low,
                           result_ch.drive_low);
                    fail_count++;
                end
                if (result_ch.temp_tenths !== want.temp_tenths)
                begin
                    $error("temp_tenths: expected %0d, got %0d", $signed(want.temp_tenths),
                           $signed(result_ch.temp_tenths));
                    fail_count++;
                end
                if (result_ch.temp_valid !== want.temp_valid)
                begin
                    $error("temp_valid: expected %0b, got %0b", want.temp_valid,
                           result_ch.temp_valid);
                    fail_count++;
                end
                if (result_ch.over_limit !== want.over_limit)
                begin
                    $error("over_limit: expected %0b, got %0b", want.over_limit,
                           result_ch.over_limit);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase_no;
        int count;
        int random_items;
        int readings_goal;
        int limit_pick;

        // Hold every input at a known value through reset
        rst_n = 1'b0;
        line_ch.valid = 1'b0;
        line_ch.line_level = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data = '0;

        bus_cfg.alarm_limit     = ALARM_LIMIT_RST;
        bus_cfg.reset_low_ticks = RESET_LOW_RST;
        bus_cfg.recovery_ticks  = RECOVERY_RST;
        bus_cfg.slot_ticks      = SLOT_RST;
        bus_cfg.short_low_ticks = SHORT_LOW_RST;
        bus_cfg.sample_ticks    = SAMPLE_RST;
        bus_phase   = PH_RESET1;
        tick_count  = '0;
        bit_idx     = '0;
        second_byte = 1'b0;
        shift_byte  = '0;
        low_byte    = '0;
        last_temp   = '0;
        alarm       = 1'b0;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset timing is far too slow for a full round; just watch the
        // opening of the first reset pulse under the power-up values.
        queue_ticks(20, 0, 1'b1);
        wait_idle();

        // Shrink the timing mid-pulse: the running count is already past
        // the new length, so the pulse ends at once.
        apply_timing(16'd330, 16'd1, 16'd1, 16'd2, 8'd1, 8'd1);
        // Straddle the default threshold: 330.5 rounds down, 331 trips
        run_word(16'd528);
        run_word(16'd529);
        // Minus one sixteenth rounds to zero
        run_word(16'hFFFF);

        // Sample point past the end of the slot; lowest possible limit
        apply_timing(16'h8000, 16'd1, 16'd1, 16'd2, 8'd1, 8'd200);
        run_word(16'h8000);

        // Zero-length timing: every phase and slot takes a single tick
        apply_timing(16'h7FFF, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
        run_word(16'h7FFF);

        // One-tick slots: a written zero is never pulled low
        apply_timing(16'hB000, 16'd0, 16'd0, 16'd1, 8'd0, 8'd0);
        run_word(16'h0001);

        // Largest values; only the start of a round fits in the run
        apply_timing(16'd20479, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF);
        cur_word = 16'h7FFF;
        queue_ticks(40, 0, 1'b1);
        wait_idle();

        // Writes to unused indexes must leave the block untouched
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_SPARE_HI, 16'($urandom));

        // Random phases: fresh timing each time, mostly well-formed reads
        // with a share of free line noise. Phase 1 runs without idling;
        // phase 2 holds the receiver off while ticks keep coming.
        phase_no = 0;
        random_items = 0;
        readings_goal = readings_done + RANDOM_READINGS;
        while (random_items < RANDOM_TICKS || readings_done < readings_goal || phase_no < 3)
        begin
            idle_on = (phase_no != 1);
            limit_pick = $urandom_range(40959) - 20480;
            case ($urandom_range(5))
                0: limit_pick = -20480;
                1: limit_pick = 20479;
                2: limit_pick = -32768;
                3: limit_pick = 32767;
                default: ;
            endcase
            if ($urandom_range(7) == 0)
            begin
                apply_timing(limit_pick[15:0], 16'($urandom_range(1, 40)),
                             16'($urandom_range(1, 40)), 16'($urandom_range(2, 24)),
                             8'($urandom_range(1, 30)), 8'($urandom_range(1, 30)));
            end
            else
            begin
                apply_timing(limit_pick[15:0], 16'($urandom_range(1, 4)),
                             16'($urandom_range(1, 4)), 16'($urandom_range(2, 5)),
                             8'($urandom_range(1, 3)), 8'($urandom_range(1, 6)));
            end
            count = $urandom_range(40, 120);
            queue_ticks(count, 15, 1'b0);
            if (phase_no == 2)
            begin
                holds_asked++;
            end
            random_items += count;
            // Sender pauses here until the block has drained
            wait_idle();
            phase_no++;
        end
        idle_on = 1'b1;

        // Let any stray beat show up before judging
        repeat (8) @(negedge clk);
        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/owtp_pkg.sv
rtl/core/owtp_in_if.sv
rtl/core/owtp_out_if.sv
rtl/core/owtp_cfg_if.sv
rtl/core/owtp_cfg.sv
rtl/core/owtp_seq.sv
rtl/core/onewire_temp_poll_alarm.sv
dv/onewire_temp_poll_alarm_test.sv
